[hdl/btts_pkg.sv]
`default_nettype none

package btts_pkg;

  // Default geometry of the parser
  localparam int unsigned POSITION_BITS_DEF       = 16;
  localparam int unsigned MAX_TAG_EXTRA_BYTES_DEF = 10;
  localparam int unsigned MAX_LENGTH_BYTES_DEF    = 3;

  // Fixed field widths
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TAG   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b1;

  // Tag number bits all set in the first tag byte: more tag bytes follow
  localparam logic [4:0] TAG_NUM_EXTENDED = 5'h1F;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LEN_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [OFFSET_W-1:0] match_offset;
  } result_t;

endpackage

`default_nettype wire

[hdl/btts_in_if.sv]
`default_nettype none

interface btts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

[hdl/btts_out_if.sv]
`default_nettype none

interface btts_out_if;
  logic                          valid;
  logic                          ready;
  btts_pkg::status_e             status;
  logic [btts_pkg::OFFSET_W-1:0] match_offset;

  modport source (output valid, output status, output match_offset, input ready);
  modport sink   (input valid, input status, input match_offset, output ready);
endinterface

`default_nettype wire

[hdl/btts_parser.sv]
`default_nettype none

module btts_parser #(
  parameter int unsigned POSITION_BITS       = btts_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_TAG_EXTRA_BYTES = btts_pkg::MAX_TAG_EXTRA_BYTES_DEF,
  parameter int unsigned MAX_LENGTH_BYTES    = btts_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         beat_i,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         end_of_buffer_i,
  input  wire logic [btts_pkg::TAG_W-1:0]   search_tag_i,
  input  wire logic [btts_pkg::OFFSET_W-1:0] start_offset_i,
  output logic                              res_valid_o,
  output btts_pkg::result_t                 res_o
);

  localparam int unsigned CW  = (POSITION_BITS > btts_pkg::OFFSET_W) ?
                                POSITION_BITS : btts_pkg::OFFSET_W;
  localparam int unsigned TCW = $clog2(MAX_TAG_EXTRA_BYTES + 2);
  localparam int unsigned LW  = 8 * MAX_LENGTH_BYTES;
  localparam int unsigned LLW = (MAX_LENGTH_BYTES > 1) ? $clog2(MAX_LENGTH_BYTES + 1) : 1;

  localparam logic [2:0] PH_SKIP      = 3'd0;
  localparam logic [2:0] PH_TAG_FIRST = 3'd1;
  localparam logic [2:0] PH_TAG_MORE  = 3'd2;
  localparam logic [2:0] PH_LEN_FIRST = 3'd3;
  localparam logic [2:0] PH_LEN_MORE  = 3'd4;
  localparam logic [2:0] PH_VALUE     = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  logic [2:0]               phase_q, phase_d, phase_eff;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] hdr_q, hdr_d;
  logic [TCW-1:0]           tag_cnt_q, tag_cnt_d, tag_cnt_inc;
  logic [15:0]              tag_val_q, tag_val_d;
  logic [LLW-1:0]           len_left_q, len_left_d;
  logic [LW-1:0]            len_q, len_d;
  logic [LW+7:0]            len_shift;
  logic [LW-1:0]            hdr_len;
  logic                     hdr_done;
  logic [15:0]              tag_sel;
  logic                     tag_hit;
  logic [CW-1:0]            pos_w, skip_w, hdr_w;

  assign pos_w  = CW'(pos_q);
  assign skip_w = CW'(start_offset_i);
  assign hdr_w  = CW'(hdr_q);

  // Pick the tag bytes that take part in the compare
  always_comb begin
    if (tag_cnt_q == TCW'(2)) begin
      tag_sel = tag_val_q;
    end else if (tag_cnt_q <= TCW'(1)) begin
      tag_sel = {8'h00, tag_val_q[7:0]};
    end else begin
      tag_sel = {8'h00, tag_val_q[15:8]};
    end
  end

  assign tag_hit     = (tag_sel == search_tag_i);
  assign tag_cnt_inc = tag_cnt_q + TCW'(1);
  assign len_shift   = {len_q, data_byte_i};

  // Decode one byte of the stream
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    tag_cnt_d   = tag_cnt_q;
    tag_val_d   = tag_val_q;
    len_left_d  = len_left_q;
    len_d       = len_q;
    hdr_done    = 1'b0;
    hdr_len     = '0;
    res_valid_o = 1'b0;
    res_o.status       = btts_pkg::ST_FOUND;
    res_o.match_offset = '0;

    phase_eff = phase_q;
    if (phase_q == PH_SKIP && pos_w >= skip_w) begin
      phase_eff = PH_TAG_FIRST;
    end

    if (beat_i) begin
      case (phase_eff)
        PH_TAG_FIRST: begin
          hdr_d     = pos_q;
          tag_val_d = {8'h00, data_byte_i};
          tag_cnt_d = TCW'(1);
          phase_d   = (data_byte_i[4:0] == btts_pkg::TAG_NUM_EXTENDED) ?
                      PH_TAG_MORE : PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          tag_cnt_d = tag_cnt_inc;
          if (tag_cnt_inc == TCW'(2)) begin
            tag_val_d = {tag_val_q[7:0], data_byte_i};
          end
          if (!(data_byte_i[7] && tag_cnt_q < TCW'(MAX_TAG_EXTRA_BYTES))) begin
            phase_d = PH_LEN_FIRST;
          end
        end
        PH_LEN_FIRST: begin
          if (data_byte_i[7]) begin
            if (data_byte_i[6:0] > 7'(MAX_LENGTH_BYTES)) begin
              res_valid_o  = 1'b1;
              res_o.status = btts_pkg::ST_LEN_ERROR;
            end else if (data_byte_i[6:0] == 7'd0) begin
              len_d    = '0;
              hdr_done = 1'b1;
            end else begin
              len_d      = '0;
              len_left_d = LLW'(data_byte_i[6:0]);
              phase_d    = PH_LEN_MORE;
            end
          end else begin
            hdr_done = 1'b1;
            hdr_len  = LW'(data_byte_i);
          end
        end
        PH_LEN_MORE: begin
          len_d      = len_shift[LW-1:0];
          len_left_d = len_left_q - LLW'(1);
          if (len_left_q == LLW'(1)) begin
            hdr_done = 1'b1;
            hdr_len  = len_shift[LW-1:0];
          end
        end
        PH_VALUE: begin
          len_d = len_q - LW'(1);
          if (len_q == LW'(1)) begin
            phase_d = PH_TAG_FIRST;
          end
        end
        default: begin
        end
      endcase

      // Header complete: report a hit or move past the value
      if (hdr_done) begin
        if (tag_hit) begin
          res_valid_o        = 1'b1;
          res_o.status       = btts_pkg::ST_FOUND;
          res_o.match_offset = hdr_w[btts_pkg::OFFSET_W-1:0];
        end else if (hdr_len == '0) begin
          phase_d = PH_TAG_FIRST;
        end else begin
          len_d   = hdr_len;
          phase_d = PH_VALUE;
        end
      end

      if (res_valid_o) begin
        phase_d = PH_DONE;
      end else if (end_of_buffer_i && phase_q != PH_DONE) begin
        res_valid_o  = 1'b1;
        res_o.status = btts_pkg::ST_NOT_FOUND;
      end

      // Saturate the byte position
      if (pos_q != '1) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end

      // Drop all buffer state after the final byte
      if (end_of_buffer_i) begin
        phase_d    = PH_SKIP;
        pos_d      = '0;
        hdr_d      = '0;
        tag_cnt_d  = '0;
        tag_val_d  = '0;
        len_left_d = '0;
        len_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SKIP;
      pos_q      <= '0;
      hdr_q      <= '0;
      tag_cnt_q  <= '0;
      tag_val_q  <= '0;
      len_left_q <= '0;
      len_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      hdr_q      <= hdr_d;
      tag_cnt_q  <= tag_cnt_d;
      tag_val_q  <= tag_val_d;
      len_left_q <= len_left_d;
      len_q      <= len_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ber_tlv_top_level_tag_search_top.sv]
// Top-level BER-TLV tag search over a byte stream.
// in_ch carries one buffer byte per beat, with end_of_buffer set on the
// final byte. The block skips start_offset bytes, then walks the top-level
// TLV objects and reports on out_ch at most one result per buffer: found
// (with the header offset), not found, or a length field too long.
// Configuration: write search_tag (index 0) or start_offset (index 1) on
// cfg_we_i/cfg_idx_i/cfg_wdata_i while no buffer is in flight.
// Throughput: one byte per cycle while in_ch.ready is high; the header
// decoder updates its state in the cycle the byte is accepted.
// Result: a result is registered in the result register, or in the skid
// register while the result register is full and out_ch.ready is low.
// Stall: a result register plus a skid register hold up to two results;
// in_ch.ready drops only while the skid register is occupied.
// Reset: clears the registers to zero, the parser to the skip phase and
// both result registers to empty.
`default_nettype none

module ber_tlv_top_level_tag_search_top #(
  parameter int unsigned POSITION_BITS       = btts_pkg::POSITION_BITS_DEF,
  parameter int unsigned MAX_TAG_EXTRA_BYTES = btts_pkg::MAX_TAG_EXTRA_BYTES_DEF,
  parameter int unsigned MAX_LENGTH_BYTES    = btts_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  btts_in_if.sink                              in_ch,
  btts_out_if.source                           out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [btts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [btts_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [btts_pkg::TAG_W-1:0]    search_tag_q;
  logic [btts_pkg::OFFSET_W-1:0] start_offset_q;
  logic                          beat;
  logic                          res_valid;
  btts_pkg::result_t             res;
  logic                          out_valid_q, skid_valid_q;
  btts_pkg::result_t             out_q, skid_q;
  logic                          pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_tag_q   <= '0;
      start_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btts_pkg::CFG_SEARCH_TAG:   search_tag_q   <= cfg_wdata_i;
        btts_pkg::CFG_START_OFFSET: start_offset_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !skid_valid_q;
  assign beat        = in_ch.valid && in_ch.ready;

  btts_parser #(
    .POSITION_BITS      (POSITION_BITS),
    .MAX_TAG_EXTRA_BYTES(MAX_TAG_EXTRA_BYTES),
    .MAX_LENGTH_BYTES   (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .data_byte_i    (in_ch.data_byte),
    .end_of_buffer_i(in_ch.end_of_buffer),
    .search_tag_i   (search_tag_q),
    .start_offset_i (start_offset_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign pop = out_valid_q && out_ch.ready;

  // Result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.status       = out_q.status;
  assign out_ch.match_offset = out_q.match_offset;

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [7:0]  LONG_FORM   = 8'h80;

  typedef enum logic [2:0] {
    P_SKIP, P_TAG0, P_TAGN, P_LEN0, P_LENN, P_VALUE, P_DONE
  } parse_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } byte_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [btts_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [btts_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  btts_in_if  in_ch ();
  btts_out_if out_ch ();

  ber_tlv_top_level_tag_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Stimulus and scoreboard storage
  logic [7:0]          frame_q[$];
  byte_beat_t          pend_q[$];
  btts_pkg::result_t   expected_q[$];
  bit                  idle_on;
  bit                  in_taken;
  int unsigned         src_gap;
  int unsigned         snk_stall;
  int unsigned         err_count;
  int unsigned         quiet_cycles;

  // Shadow of the parser state and registers
  logic [15:0]  want_tag;
  logic [15:0]  skip_len;
  parse_state_e parse_state;
  logic [15:0]  byte_pos;
  logic [15:0]  hdr_start;
  logic [3:0]   tag_cnt;
  logic [15:0]  tag_val;
  logic [1:0]   len_left;
  logic [23:0]  val_len;
  logic [23:0]  val_left;
  bit           answered;

  function automatic void clear_parse();
    parse_state = P_SKIP;
    byte_pos    = '0;
    hdr_start   = '0;
    tag_cnt     = '0;
    tag_val     = '0;
    len_left    = '0;
    val_len     = '0;
    val_left    = '0;
    answered    = 1'b0;
  endfunction

  // Compare the decoded tag; on a miss, set up the value skip
  function automatic bit header_complete();
    logic [15:0] key;
    if (tag_cnt == 2) begin
      key = tag_val;
    end else if (tag_cnt <= 1) begin
      key = {8'h00, tag_val[7:0]};
    end else begin
      key = {8'h00, tag_val[15:8]};
    end
    if (key == want_tag) return 1'b1;
    if (val_len == 0) begin
      parse_state = P_TAG0;
    end else begin
      val_left    = val_len;
      parse_state = P_VALUE;
    end
    return 1'b0;
  endfunction

  // Advance the shadow parser by one byte; return 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic eob,
                                    output btts_pkg::result_t res);
    bit found;
    bit hit;
    found            = 1'b0;
    hit              = 1'b0;
    res.status       = btts_pkg::ST_FOUND;
    res.match_offset = '0;
    if (parse_state == P_SKIP && byte_pos >= skip_len) parse_state = P_TAG0;
    case (parse_state)
      P_TAG0: begin
        hdr_start   = byte_pos;
        tag_val     = {8'h00, b};
        tag_cnt     = 1;
        parse_state = (b[4:0] == btts_pkg::TAG_NUM_EXTENDED) ? P_TAGN : P_LEN0;
      end
      P_TAGN: begin
        tag_cnt = tag_cnt + 1;
        if (tag_cnt == 2) tag_val = {tag_val[7:0], b};
        if (!(b[7] && (tag_cnt - 1) < btts_pkg::MAX_TAG_EXTRA_BYTES_DEF))
          parse_state = P_LEN0;
      end
      P_LEN0: begin
        if (b[7]) begin
          if (b[6:0] > btts_pkg::MAX_LENGTH_BYTES_DEF) begin
            res.status = btts_pkg::ST_LEN_ERROR;
            hit        = 1'b1;
          end else begin
            val_len = '0;
            if (b[6:0] == 0) begin
              found = header_complete();
            end else begin
              len_left    = b[1:0];
              parse_state = P_LENN;
            end
          end
        end else begin
          val_len = {16'h0000, b};
          found   = header_complete();
        end
      end
      P_LENN: begin
        val_len  = {val_len[15:0], b};
        len_left = len_left - 1;
        if (len_left == 0) found = header_complete();
      end
      P_VALUE: begin
        val_left = val_left - 1;
        if (val_left == 0) parse_state = P_TAG0;
      end
      default: begin
      end
    endcase
    if (found) begin
      res.status       = btts_pkg::ST_FOUND;
      res.match_offset = hdr_start;
      hit              = 1'b1;
    end
    if (hit) begin
      parse_state = P_DONE;
      answered    = 1'b1;
    end else if (eob && !answered) begin
      res.status       = btts_pkg::ST_NOT_FOUND;
      res.match_offset = '0;
      hit              = 1'b1;
    end
    if (byte_pos != '1) byte_pos = byte_pos + 1;
    if (eob) clear_parse();
    return hit;
  endfunction

  task automatic flag_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Buffer builders
  function automatic void push_random_bytes(int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void push_random_tag();
    int unsigned n;
    logic [7:0]  b;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
    b = $urandom;
    if (n == 1) begin
      if (b[4:0] == btts_pkg::TAG_NUM_EXTENDED) b[0] = 1'b0;
    end else begin
      b[4:0] = btts_pkg::TAG_NUM_EXTENDED;
    end
    frame_q.push_back(b);
    for (int k = 2; k <= n; k++) begin
      b = $urandom;
      // the eleventh byte ends the tag whatever its continuation bit says
      if (k < n) begin
        b[7] = 1'b1;
      end else if (k < 11) begin
        b[7] = 1'b0;
      end
      frame_q.push_back(b);
    end
  endfunction

  function automatic void push_match_tag(logic [15:0] tag);
    if (tag[15:8] == 0 && tag[4:0] != btts_pkg::TAG_NUM_EXTENDED) begin
      frame_q.push_back(tag[7:0]);
    end else if (tag[15:8] == 0) begin
      // three-byte tag compared on its first byte
      frame_q.push_back(tag[7:0]);
      frame_q.push_back(8'($urandom) | LONG_FORM);
      frame_q.push_back(8'($urandom) & ~LONG_FORM);
    end else if (tag[12:8] == btts_pkg::TAG_NUM_EXTENDED && !tag[7]) begin
      frame_q.push_back(tag[15:8]);
      frame_q.push_back(tag[7:0]);
    end else begin
      push_random_tag();
    end
  endfunction

  function automatic void push_length(int unsigned vlen);
    int unsigned cnt;
    if (vlen < 128 && $urandom_range(0, 1) == 1) begin
      frame_q.push_back(8'(vlen));
      return;
    end
    if (vlen == 0) begin
      cnt = $urandom_range(0, btts_pkg::MAX_LENGTH_BYTES_DEF);
    end else if (vlen < 256) begin
      cnt = $urandom_range(1, btts_pkg::MAX_LENGTH_BYTES_DEF);
    end else begin
      cnt = $urandom_range(2, btts_pkg::MAX_LENGTH_BYTES_DEF);
    end
    frame_q.push_back(LONG_FORM | 8'(cnt));
    for (int k = cnt; k > 0; k--) frame_q.push_back(8'(vlen >> (8 * (k - 1))));
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] pick_search_tag();
    logic [7:0] hi;
    logic [7:0] lo;
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(0, 3))
      0: return {8'h00, lo[7:5],
                 (lo[4:0] == btts_pkg::TAG_NUM_EXTENDED) ? 5'h0E : lo[4:0]};
      1: return {hi[7:5], btts_pkg::TAG_NUM_EXTENDED, 1'b0, lo[6:0]};
      2: return {8'h00, lo[7:5], btts_pkg::TAG_NUM_EXTENDED};
      default: return {hi, lo};
    endcase
  endfunction

  // Mostly well-formed TLV walks, some noise, errors and truncation
  function automatic void build_random_buffer(logic [15:0] tag, int unsigned skip);
    int unsigned vlen;
    push_random_bytes(skip);
    if ($urandom_range(0, 9) < 2) begin
      push_random_bytes($urandom_range(1, 24));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      vlen = pick_len();
      push_random_tag();
      push_length(vlen);
      push_random_bytes(vlen);
    end
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        vlen = pick_len();
        push_match_tag(tag);
        push_length(vlen);
        push_random_bytes($urandom_range(0, vlen));
      end
      3: begin
        push_random_tag();
        frame_q.push_back(LONG_FORM |
                          8'($urandom_range(btts_pkg::MAX_LENGTH_BYTES_DEF + 1, 127)));
      end
      4: begin
        push_random_tag();
        frame_q.push_back(LONG_FORM | 8'(btts_pkg::MAX_LENGTH_BYTES_DEF));
        push_random_bytes($urandom_range(3, 6));
      end
      default: begin
      end
    endcase
    push_random_bytes($urandom_range(0, 3));
    if (frame_q.size() == 0) push_random_bytes(1);
  endfunction

  // Move the built buffer to the driver, marking its last byte
  function automatic void queue_buffer();
    byte_beat_t beat;
    foreach (frame_q[i]) begin
      beat.data = frame_q[i];
      beat.eob  = (i == frame_q.size() - 1);
      pend_q.push_back(beat);
    end
    frame_q.delete();
  endfunction

  task automatic write_reg(input logic [btts_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [btts_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait until every byte is taken and every result has arrived
  task automatic wait_idle();
    while (pend_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drive input beats from the pending queue, with random gaps
  always @(negedge clk_i) begin : feed_bytes
    byte_beat_t beat;
    if (rst_ni) begin
      if (in_ch.valid && !in_taken) begin
        // hold the beat until the block takes it
      end else if (src_gap != 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (pend_q.size() != 0 && idle_on && $urandom_range(0, 11) == 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= $urandom_range(0, 9);
      end else if (pend_q.size() != 0) begin
        beat                 = pend_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= beat.data;
        in_ch.end_of_buffer <= beat.eob;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk_i) begin : pace_results
    if (rst_ni) begin
      if (snk_stall != 0) begin
        out_ch.ready <= 1'b0;
        snk_stall    <= snk_stall - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        snk_stall    <= $urandom_range(0, 9);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Track register writes, predict accepted bytes, check results
  always @(posedge clk_i) begin : score
    btts_pkg::result_t pred;
    btts_pkg::result_t want;
    if (rst_ni) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          btts_pkg::CFG_SEARCH_TAG:   want_tag = cfg_wdata_i;
          btts_pkg::CFG_START_OFFSET: skip_len = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.data_byte, in_ch.end_of_buffer, pred)) expected_q.push_back(pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: status %0d, offset %0d",
                                  out_ch.status, out_ch.match_offset));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.status !== want.status)
            flag_mismatch($sformatf("status: expected %0d, got %0d", want.status, out_ch.status));
          if (out_ch.match_offset !== want.match_offset)
            flag_mismatch($sformatf("match_offset: expected %0d, got %0d",
                                    want.match_offset, out_ch.match_offset));
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_items;
    logic [15:0] tag_cfg;
    logic [15:0] skip_cfg;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = btts_pkg::CFG_SEARCH_TAG;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready        = 1'b0;
    in_taken            = 1'b0;
    idle_on             = 1'b1;
    src_gap             = 0;
    snk_stall           = 0;
    err_count           = 0;
    quiet_cycles        = 0;
    want_tag            = '0;
    skip_len            = '0;
    clear_parse();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: tag zero found at once, trailing byte absorbed
    frame_q = {8'h00, 8'h00, 8'h00};
    queue_buffer();
    wait_idle();

    write_reg(btts_pkg::CFG_SEARCH_TAG, 16'h9F21);
    // two-byte tag found after a long-form object, zero length via bare count
    frame_q = {8'h5A, 8'h81, 8'h02, 8'hAA, 8'hBB, 8'h9F, 8'h21, 8'h80, 8'hCC};
    queue_buffer();
    // length count too big
    frame_q = {8'h01, 8'h84, 8'h00};
    queue_buffer();
    // length count too big beats a matching tag
    frame_q = {8'h9F, 8'h21, 8'hFF};
    queue_buffer();
    // buffer ends inside a value
    frame_q = {8'h01, 8'h83, 8'hFF, 8'hFF, 8'hFF, 8'h11};
    queue_buffer();
    // buffer ends inside a header
    frame_q = {8'h9F};
    queue_buffer();
    // tag capped at eleven bytes, the next byte is taken as length
    frame_q = {8'h1F};
    repeat (10) frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    queue_buffer();
    wait_idle();

    // Skip region: found just past it, and a buffer ending inside it
    write_reg(btts_pkg::CFG_SEARCH_TAG, 16'h0041);
    write_reg(btts_pkg::CFG_START_OFFSET, 16'd3);
    frame_q = {8'h41, 8'h41, 8'h41, 8'h41, 8'h00};
    queue_buffer();
    frame_q = {8'h41, 8'h41};
    queue_buffer();
    wait_idle();

    // Three-byte tag compared on its first byte
    write_reg(btts_pkg::CFG_SEARCH_TAG, 16'h00BF);
    write_reg(btts_pkg::CFG_START_OFFSET, 16'd0);
    frame_q = {8'hBF, 8'h81, 8'h01, 8'h00};
    queue_buffer();
    wait_idle();

    // Largest registers: the skip region is never left
    write_reg(btts_pkg::CFG_SEARCH_TAG, 16'hFFFF);
    write_reg(btts_pkg::CFG_START_OFFSET, 16'hFFFF);
    push_random_bytes(10);
    queue_buffer();
    wait_idle();

    // Random phases, each with its own settings; the last one without idling
    for (int p = 0; p < 6; p++) begin
      tag_cfg  = pick_search_tag();
      skip_cfg = (p == 0) ? 16'd0 : 16'($urandom_range(0, 6));
      idle_on  = (p < 5);
      write_reg(btts_pkg::CFG_SEARCH_TAG, tag_cfg);
      write_reg(btts_pkg::CFG_START_OFFSET, skip_cfg);
      phase_items = 0;
      while (phase_items < 100) begin
        build_random_buffer(tag_cfg, skip_cfg);
        phase_items += frame_q.size();
        queue_buffer();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
